### sv/rotated_checkerboard_generator_defines.svh
// ----------------------------------------------------------------------------
// Rotated checkerboard generator: assertion macros
// Shared property shorthands for the checker of the pattern generator.
// ----------------------------------------------------------------------------
`ifndef ROTATED_CHECKERBOARD_GENERATOR_DEFINES_SVH
`define ROTATED_CHECKERBOARD_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/rcg_pkg.sv
// ----------------------------------------------------------------------------
// rcg_pkg
// Types, constants and helper functions of the rotated checkerboard generator.
// ----------------------------------------------------------------------------
package rcg_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  // Only the bits up to the parity bit of a pattern coordinate matter
  localparam int LB = FRAC_BITS + 1;

  localparam bit IN_SIGNED = (COORD_BITS <= 16);
  localparam int KEEP_BITS = IN_SIGNED ? COORD_BITS : 16;
  localparam int SIGN_POS  = IN_SIGNED ? COORD_BITS - 1 : 15;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0] THREE_Q16 = 18'd196608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX    = 3'd0,
    REG_COEF_XY    = 3'd1,
    REG_COEF_YX    = 3'd2,
    REG_COEF_YY    = 3'd3,
    REG_CONST_X    = 3'd4,
    REG_CONST_Y    = 3'd5,
    REG_FUZZ_WIDTH = 3'd6,
    REG_FUZZ_RECIP = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] coef_xx;
    logic [31:0] coef_xy;
    logic [31:0] coef_yx;
    logic [31:0] coef_yy;
    logic [47:0] const_x;
    logic [47:0] const_y;
    logic [16:0] fuzz_width;
    logic [31:0] fuzz_recip;
  } cfg_t;

  typedef enum logic [1:0] {
    PULSE_FLAT,
    PULSE_RISE,
    PULSE_FALL
  } pulse_kind_t;

  typedef struct packed {
    logic        span;
    logic        differ;
    pulse_kind_t kind_x;
    pulse_kind_t kind_y;
    logic [15:0] d_x;
    logic [15:0] d_y;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Pixel coordinate as a COORD_BITS-bit value, reduced to LB bits
  function automatic logic [LB-1:0] coord_ext(input logic [15:0] v);
    logic [31:0] mask;
    logic [31:0] m;
    logic [31:0] e;
    mask = (32'd1 << KEEP_BITS) - 32'd1;
    m    = {16'b0, v} & mask;
    if (IN_SIGNED && m[SIGN_POS]) begin
      e = m | ~mask;
    end else begin
      e = m;
    end
    return e[LB-1:0];
  endfunction

  // Axis fraction rescaled to Q0.16, truncating
  function automatic logic [15:0] frac_to_q16(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS+15:0] t;
    t = {f, 16'b0};
    return t[FRAC_BITS+15:FRAC_BITS];
  endfunction

endpackage

### sv/rcg_queue.sv
// ----------------------------------------------------------------------------
// rcg_queue
// Short FIFO between the classifying front end and the fuzz back end.
// ----------------------------------------------------------------------------
module rcg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rcg_pkg::q_entry_t push_data,
  input  logic              pop,
  output rcg_pkg::q_entry_t pop_data,
  output rcg_pkg::q_stat_t  stat
);
  import rcg_pkg::*;

  q_entry_t           mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]       cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### sv/rcg_front.sv
// ----------------------------------------------------------------------------
// rcg_front
// Accepts pixels, applies the affine transform and classifies each axis.
// ----------------------------------------------------------------------------
module rcg_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_col,
  input  logic [15:0]       in_row,
  input  logic              in_span_end,
  input  rcg_pkg::cfg_t     cfg,
  input  rcg_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output rcg_pkg::q_entry_t q_data
);
  import rcg_pkg::*;

  typedef struct packed {
    pulse_kind_t kind;
    logic [15:0] d;
  } cls_t;

  logic          advance;
  logic          s1_valid_r;
  logic [LB-1:0] s1_pxa_r, s1_pxb_r, s1_pya_r, s1_pyb_r;
  logic [LB-1:0] col_e, row_e;
  logic          s1_span_r;
  logic          s2_valid_r;
  q_entry_t      s2_entry_r, s2_entry_nxt;
  logic [LB-1:0] px, py;
  cls_t          cls_x, cls_y;

  function automatic cls_t classify(input logic [15:0] u, input logic [16:0] w);
    cls_t        c;
    logic [17:0] sum;
    sum = {2'b0, u} + {1'b0, w};
    if ({1'b0, u} >= w) begin
      if (sum < 18'd65536) begin
        c.kind = PULSE_FLAT;
        c.d    = '0;
      end else begin
        c.kind = PULSE_FALL;
        c.d    = sum[15:0];
      end
    end else begin
      c.kind = PULSE_RISE;
      c.d    = u;
    end
    return c;
  endfunction

  // Hold both stages while the head item cannot enter a full queue
  assign advance  = !(s2_valid_r && q_stat.full);
  assign in_ready = advance;
  assign col_e    = coord_ext(in_col);
  assign row_e    = coord_ext(in_row);

  always_comb begin
    px    = s1_pxa_r + s1_pxb_r + cfg.const_x[LB-1:0];
    py    = s1_pya_r + s1_pyb_r + cfg.const_y[LB-1:0];
    cls_x = classify(frac_to_q16(px[FRAC_BITS-1:0]), cfg.fuzz_width);
    cls_y = classify(frac_to_q16(py[FRAC_BITS-1:0]), cfg.fuzz_width);
    s2_entry_nxt.span   = s1_span_r;
    s2_entry_nxt.differ = px[FRAC_BITS] ^ py[FRAC_BITS];
    s2_entry_nxt.kind_x = cls_x.kind;
    s2_entry_nxt.kind_y = cls_y.kind;
    s2_entry_nxt.d_x    = cls_x.d;
    s2_entry_nxt.d_y    = cls_y.d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pxa_r   <= LB'(cfg.coef_xx[LB-1:0] * col_e);
      s1_pxb_r   <= LB'(cfg.coef_xy[LB-1:0] * row_e);
      s1_pya_r   <= LB'(cfg.coef_yx[LB-1:0] * col_e);
      s1_pyb_r   <= LB'(cfg.coef_yy[LB-1:0] * row_e);
      s1_span_r  <= in_span_end;
      s2_entry_r <= s2_entry_nxt;
    end
  end

  assign q_push = s2_valid_r && advance;
  assign q_data = s2_entry_r;

endmodule

### sv/rcg_back.sv
// ----------------------------------------------------------------------------
// rcg_back
// Fuzz pulse evaluation per axis, final product and output register.
// ----------------------------------------------------------------------------
module rcg_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rcg_pkg::cfg_t     cfg,
  input  rcg_pkg::q_stat_t  q_stat,
  input  rcg_pkg::q_entry_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [16:0]       out_intensity,
  output logic              out_span_last
);
  import rcg_pkg::*;

  logic        advance;
  logic        b1_valid_r, b2_valid_r, b3_valid_r, out_valid_r;
  logic        b1_span_r, b2_span_r, b3_span_r, out_span_r;
  logic        b1_differ_r, b2_differ_r, b3_differ_r;
  pulse_kind_t b1_kx_r, b1_ky_r, b2_kx_r, b2_ky_r;
  logic [16:0] b1_sx_r, b1_sy_r;
  logic [16:0] b2_s2x_r, b2_s2y_r;
  logic [17:0] b2_tx_r, b2_ty_r;
  logic [16:0] b3_px_r, b3_py_r;
  logic [16:0] out_int_r, out_int_nxt;
  logic [33:0] sqx, sqy;
  logic [34:0] mx, my;
  logic [33:0] prod;

  function automatic logic [16:0] scale_sat(input logic [15:0] d, input logic [31:0] r);
    logic [47:0] p;
    p = {32'b0, d} * {16'b0, r};
    return (p[47:16] > 32'd65536) ? ONE_Q16 : p[32:16];
  endfunction

  function automatic logic [16:0] pulse_sel(input pulse_kind_t k, input logic [16:0] sm);
    logic [16:0] v;
    case (k)
      PULSE_FLAT: v = ONE_Q16;
      PULSE_RISE: v = sm;
      PULSE_FALL: v = ONE_Q16 - sm;
      default:    v = ONE_Q16;
    endcase
    return v;
  endfunction

  // Advance the whole back end whenever the output register can move
  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && !q_stat.empty;

  always_comb begin
    sqx  = 34'(b1_sx_r) * 34'(b1_sx_r);
    sqy  = 34'(b1_sy_r) * 34'(b1_sy_r);
    mx   = 35'(b2_s2x_r) * 35'(b2_tx_r);
    my   = 35'(b2_s2y_r) * 35'(b2_ty_r);
    prod = 34'(b3_px_r) * 34'(b3_py_r);
    if (!b3_differ_r) begin
      out_int_nxt = '0;
    end else if (prod[33:16] > {1'b0, ONE_Q16}) begin
      out_int_nxt = ONE_Q16;
    end else begin
      out_int_nxt = prod[32:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r  <= q_pop;
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      out_valid_r <= b3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b1_sx_r     <= scale_sat(q_data.d_x, cfg.fuzz_recip);
      b1_sy_r     <= scale_sat(q_data.d_y, cfg.fuzz_recip);
      b1_kx_r     <= q_data.kind_x;
      b1_ky_r     <= q_data.kind_y;
      b1_differ_r <= q_data.differ;
      b1_span_r   <= q_data.span;
      b2_s2x_r    <= sqx[32:16];
      b2_s2y_r    <= sqy[32:16];
      b2_tx_r     <= THREE_Q16 - {b1_sx_r, 1'b0};
      b2_ty_r     <= THREE_Q16 - {b1_sy_r, 1'b0};
      b2_kx_r     <= b1_kx_r;
      b2_ky_r     <= b1_ky_r;
      b2_differ_r <= b1_differ_r;
      b2_span_r   <= b1_span_r;
      b3_px_r     <= pulse_sel(b2_kx_r, mx[32:16]);
      b3_py_r     <= pulse_sel(b2_ky_r, my[32:16]);
      b3_differ_r <= b2_differ_r;
      b3_span_r   <= b2_span_r;
      out_int_r   <= out_int_nxt;
      out_span_r  <= b3_span_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_intensity = out_int_r;
  assign out_span_last = out_span_r;

endmodule

### sv/rotated_checkerboard_generator.sv
// ----------------------------------------------------------------------------
// rotated_checkerboard_generator
// Streaming checkerboard test pattern with affine mapping and soft edges.
// ----------------------------------------------------------------------------
// Takes one pixel (col, row) per transaction and returns one Q1.16 intensity
// per transaction, in order, together with a copy of the span marker. The
// block sustains one pixel per clock while the output is not stalled and the
// queue is not full. Each result passes through seven register stages, the
// first loaded at the edge that accepts its pixel: two front stages (transform
// products, then sum and edge classification), one in the four-entry queue
// and four back stages (scale by the reciprocal, square, smoothstep, final
// product into the output register).
// A stall on the output holds the back end; the queue absorbs up to four
// pixels before the input is held. Program the registers only while no
// pixel is in flight. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module rotated_checkerboard_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [rcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [15:0]                      in_col,
  input  logic [15:0]                      in_row,
  input  logic                             in_span_end,
  // intensity output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [16:0]                      out_intensity,
  output logic                             out_span_last
);
  import rcg_pkg::*;

  cfg_t     cfg_r;
  q_stat_t  q_stat;
  q_entry_t q_push_data, q_pop_data;
  logic     q_push, q_pop;

  // Register file: reset to the identity-like default of an 8192 scale,
  // drop writes to codes that name no register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_xx    <= 32'd8192;
      cfg_r.coef_xy    <= '0;
      cfg_r.coef_yx    <= '0;
      cfg_r.coef_yy    <= 32'd8192;
      cfg_r.const_x    <= '0;
      cfg_r.const_y    <= '0;
      cfg_r.fuzz_width <= '0;
      cfg_r.fuzz_recip <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_XX:    cfg_r.coef_xx    <= cfg_wdata[31:0];
        REG_COEF_XY:    cfg_r.coef_xy    <= cfg_wdata[31:0];
        REG_COEF_YX:    cfg_r.coef_yx    <= cfg_wdata[31:0];
        REG_COEF_YY:    cfg_r.coef_yy    <= cfg_wdata[31:0];
        REG_CONST_X:    cfg_r.const_x    <= cfg_wdata[47:0];
        REG_CONST_Y:    cfg_r.const_y    <= cfg_wdata[47:0];
        REG_FUZZ_WIDTH: cfg_r.fuzz_width <= cfg_wdata[16:0];
        REG_FUZZ_RECIP: cfg_r.fuzz_recip <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Front end: transform, parity and per-axis edge classification
  rcg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_col      (in_col),
    .in_row      (in_row),
    .in_span_end (in_span_end),
    .cfg         (cfg_r),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  // Decoupling queue: lets either side stall on its own
  rcg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .stat      (q_stat)
  );

  // Back end: smoothstep pulses, product and output register
  rcg_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_intensity (out_intensity),
    .out_span_last (out_span_last)
  );

endmodule

### sv/rcg_checker.sv
// ----------------------------------------------------------------------------
// rcg_checker
// Port-level checks of the rotated checkerboard generator, bound to the top.
// ----------------------------------------------------------------------------
`include "rotated_checkerboard_generator_defines.svh"

module rcg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [16:0] out_intensity
);

  logic [7:0] pend_r, pend_nxt;

  // Count transactions accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    case ({in_valid && in_ready, out_valid && out_ready})
      2'b10:   pend_nxt = pend_r + 1'b1;
      2'b01:   pend_nxt = pend_r - 1'b1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `RCG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output dropped while stalled")
  `RCG_ASSERT_NOW(a_int_range, out_valid, out_intensity <= 17'd65536, "intensity above 1.0")
  `RCG_ASSERT_NOW(a_no_extra, out_valid, pend_r != 8'd0, "result without an accepted pixel")

endmodule

bind rotated_checkerboard_generator rcg_checker u_rcg_checker (.*);
